// ----- rtl/srs_pkg.sv -----
// ----------------------------------------------------------------------------
// srs_pkg
// Shared types and constants for the stable rank sort core and its cells.
// ----------------------------------------------------------------------------
package srs_pkg;

  // Width of one key.
  localparam int KEY_W = 32;

  typedef logic signed [KEY_W-1:0] key_t;

  // Per-cycle command broadcast to every cell of the chain.
  typedef struct packed {
    logic ins;  // insert the broadcast key at its sorted place
    logic shl;  // shift the whole chain one cell toward cell 0
  } srs_ctl_t;

endpackage

// ----- rtl/srs_cell.sv -----
// ----------------------------------------------------------------------------
// srs_cell
// One cell of the sorting chain: holds one key and its valid bit.
// ----------------------------------------------------------------------------
module srs_cell (
  input  logic              clk,
  input  logic              rst_n,
  input  srs_pkg::srs_ctl_t ctl,
  input  srs_pkg::key_t     ins_key,
  // Left neighbor (toward cell 0).
  input  logic              left_valid,
  input  logic              left_gt,
  input  srs_pkg::key_t     left_key,
  // Right neighbor (away from cell 0).
  input  logic              right_valid,
  input  srs_pkg::key_t     right_key,
  // State seen by the neighbors.
  output logic              valid_o,
  output logic              gt_o,
  output srs_pkg::key_t     key_o
);

  logic          valid_r, valid_nxt;
  srs_pkg::key_t key_r, key_nxt;

  // Strictly greater keys move right; equal keys stay, which keeps ties in
  // arrival order.
  assign gt_o    = valid_r && (key_r > ins_key);
  assign valid_o = valid_r;
  assign key_o   = key_r;

  // Next state: insert step or drain shift.
  always_comb begin
    valid_nxt = valid_r;
    key_nxt   = key_r;
    if (ctl.shl) begin
      valid_nxt = right_valid;
      key_nxt   = right_key;
    end else if (ctl.ins) begin
      if (left_gt) begin
        valid_nxt = 1'b1;
        key_nxt   = left_key;
      end else if (gt_o) begin
        valid_nxt = 1'b1;
        key_nxt   = ins_key;
      end else if (!valid_r && left_valid) begin
        valid_nxt = 1'b1;
        key_nxt   = ins_key;
      end
    end
  end

  // Valid bit is control state; the key is payload.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
    key_r <= key_nxt;
  end

endmodule

// ----- rtl/stable_rank_sort_core.sv -----
// ----------------------------------------------------------------------------
// stable_rank_sort_core
// Stable sort of a batch of keys in a chain of insertion cells.
// ----------------------------------------------------------------------------
// Usage: keys enter one per item on in_key, with in_last set on the final key
// of the batch. Each accepted key is placed at once into its sorted place in
// a chain of MAX_ITEMS cells, so further keys can be taken straight away.
// Keys beyond capacity are dropped and the whole batch reports out_overflow.
// After the last key is accepted, in_ready stays low while the chain drains
// through cell 0 into the output register, one item per cycle unless stalled.
// After the state register has switched to drain, the first result enters
// the output register once it is free. Equal keys leave in their arrival
// order; out_last_out marks the final item. A stall on out_ready simply
// holds the output register and freezes the chain. Reset empties the chain
// and clears the count and overflow flag; no clearing pass is needed.
// ----------------------------------------------------------------------------
module stable_rank_sort_core #(
  parameter int MAX_ITEMS = 64
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  logic signed [31:0]   in_key,
  input  logic                 in_last,
  output logic                 out_valid,
  input  logic                 out_ready,
  output logic signed [31:0]   out_sorted_key,
  output logic                 out_last_out,
  output logic                 out_overflow
);

  localparam int CNT_W = $clog2(MAX_ITEMS + 1);

  typedef enum logic {ST_LOAD, ST_DRAIN} state_t;

  state_t            st_r;
  logic [CNT_W-1:0]  cnt_r;
  logic              ovf_r;
  logic              out_valid_r;
  srs_pkg::key_t     out_key_r;
  logic              out_last_r;
  logic              out_ovf_r;

  logic              in_fire;
  logic              full;
  logic              take;
  srs_pkg::srs_ctl_t ctl;

  logic              cell_valid [MAX_ITEMS];
  logic              cell_gt    [MAX_ITEMS];
  srs_pkg::key_t     cell_key   [MAX_ITEMS];

  // Handshake and chain control.
  assign in_ready = (st_r == ST_LOAD);
  assign in_fire  = in_valid && in_ready;
  assign full     = (cnt_r >= CNT_W'(MAX_ITEMS));
  assign take     = (st_r == ST_DRAIN) && (!out_valid_r || out_ready);
  assign ctl.ins  = in_fire && !full;
  assign ctl.shl  = take;

  // Chain of cells, cell 0 holding the smallest key.
  for (genvar i = 0; i < MAX_ITEMS; i++) begin : g_cell
    logic          lv, lg, rv;
    srs_pkg::key_t lk, rk;
    if (i == 0) begin : g_first
      assign lv = 1'b1;
      assign lg = 1'b0;
      assign lk = '0;
    end else begin : g_mid
      assign lv = cell_valid[i-1];
      assign lg = cell_gt[i-1];
      assign lk = cell_key[i-1];
    end
    if (i == MAX_ITEMS - 1) begin : g_last
      assign rv = 1'b0;
      assign rk = '0;
    end else begin : g_inner
      assign rv = cell_valid[i+1];
      assign rk = cell_key[i+1];
    end
    srs_cell u_cell (
      .clk         (clk),
      .rst_n       (rst_n),
      .ctl         (ctl),
      .ins_key     (in_key),
      .left_valid  (lv),
      .left_gt     (lg),
      .left_key    (lk),
      .right_valid (rv),
      .right_key   (rk),
      .valid_o     (cell_valid[i]),
      .gt_o        (cell_gt[i]),
      .key_o       (cell_key[i])
    );
  end

  // State, count, overflow flag and output register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r        <= ST_LOAD;
      cnt_r       <= '0;
      ovf_r       <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      // A drain step refills the output register; otherwise an accepted
      // item empties it.
      if (take) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
      unique case (st_r)
        ST_LOAD: begin
          if (in_fire) begin
            if (full) begin
              ovf_r <= 1'b1;
            end
            if (in_last) begin
              cnt_r <= '0;
              st_r  <= ST_DRAIN;
            end else if (!full) begin
              cnt_r <= cnt_r + CNT_W'(1);
            end
          end
        end
        ST_DRAIN: begin
          if (take) begin
            if (!cell_valid[1]) begin
              ovf_r <= 1'b0;
              st_r  <= ST_LOAD;
            end
          end
        end
        default: st_r <= ST_LOAD;
      endcase
    end
    if (take) begin
      out_key_r  <= cell_key[0];
      out_last_r <= !cell_valid[1];
      out_ovf_r  <= ovf_r;
    end
  end

  assign out_valid      = out_valid_r;
  assign out_sorted_key = out_key_r;
  assign out_last_out   = out_last_r;
  assign out_overflow   = out_ovf_r;

  // The chain never drains an empty cell 0.
  a_drain_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
    (st_r == ST_DRAIN) |-> cell_valid[0])
    else $error("drain with empty chain head");

  // The head of the chain stays in ascending order.
  a_head_sorted: assert property (@(posedge clk) disable iff (!rst_n)
    (cell_valid[0] && cell_valid[1]) |-> (cell_key[0] <= cell_key[1]))
    else $error("chain head out of order");

  // The fill count never passes capacity.
  a_cnt_cap: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= CNT_W'(MAX_ITEMS))
    else $error("fill count beyond capacity");

  // A final key closes loading on the next cycle.
  a_last_closes: assert property (@(posedge clk) disable iff (!rst_n)
    (in_fire && in_last) |=> !in_ready)
    else $error("input still open after final key");

endmodule

// ----- tb/tb.sv -----
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for stable_rank_sort_core.
// ----------------------------------------------------------------------------
// Keys are sent in batches through a bursty sender. A behavioral sorter
// tracks every accepted key and queues the sorted items that each final key
// should release. Each accepted result is checked against that queue.
// Batches cover single keys, extremes, repeated keys, exact capacity, dropped
// keys, a long receiver hold-off that backs the block up, and random sizes.
// ----------------------------------------------------------------------------
module tb;
  typedef srs_pkg::key_t key_t;

  localparam int MAX_ITEMS   = 64;
  localparam int KEY_TARGET  = 370;
  localparam int CYCLE_LIMIT = 200000;
  localparam int HOLD_CYCLES = 300;

  localparam key_t KEY_MIN = {1'b1, {(srs_pkg::KEY_W-1){1'b0}}};
  localparam key_t KEY_MAX = {1'b0, {(srs_pkg::KEY_W-1){1'b1}}};

  typedef enum logic {RX_ALWAYS, RX_PATTERN} rx_mode_t;
  typedef enum logic [1:0] {VAL_FULL, VAL_NARROW, VAL_EDGE} val_mode_t;

  typedef struct {
    key_t key;
    logic last;
    logic ovf;
  } sorted_item_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;

  logic in_valid = 1'b0;
  logic in_ready;
  key_t in_key = '0;
  logic in_last = 1'b0;
  logic out_valid;
  logic out_ready = 1'b0;
  key_t out_sorted_key;
  logic out_last_out;
  logic out_overflow;

  // Sorter state: keys of the open batch and whether any were dropped.
  key_t         batch_keys[$];
  logic         batch_dropped = 1'b0;
  sorted_item_t sorted_expect_q[$];

  // Sender and receiver pacing.
  int       burst_left = 0;
  rx_mode_t rx_mode = RX_PATTERN;
  logic     hold_req = 1'b0;
  int       hold_len = 0;
  int       hold_left = 0;
  logic [7:0] stall_pattern = 8'h5b;
  int       pattern_age = 0;

  // Run statistics.
  int cycle_count = 0;
  int errors = 0;
  int keys_sent = 0;
  int batches_done = 0;
  int dropped_batches = 0;
  int items_checked = 0;

  stable_rank_sort_core #(
    .MAX_ITEMS(MAX_ITEMS)
  ) dut (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_valid      (in_valid),
    .in_ready      (in_ready),
    .in_key        (in_key),
    .in_last       (in_last),
    .out_valid     (out_valid),
    .out_ready     (out_ready),
    .out_sorted_key(out_sorted_key),
    .out_last_out  (out_last_out),
    .out_overflow  (out_overflow)
  );

  // Clock.
  initial begin
    forever #2 clk = ~clk;
  end

  // Cycle counter and watchdog.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
  end

  initial begin
    while (cycle_count < CYCLE_LIMIT) @(posedge clk);
    $display("timeout after %0d cycles, %0d items still expected",
             cycle_count, sorted_expect_q.size());
    $display("status: fail");
    $finish;
  end

  // Prints one line per mismatch and counts it.
  task automatic report_mismatch(input string what, input logic [31:0] got,
                                 input logic [31:0] want);
    $display("%0t: mismatch on %s: got %0d, expected %0d", $realtime, what,
             $signed(got), $signed(want));
    errors++;
  endtask

  // Tracks one accepted key. A final key releases the whole batch in stable
  // ascending order: each key goes after every held key that is not larger.
  task automatic rank_accepted_key(input key_t k, input logic l);
    key_t ordered[$];
    int   pos;
    keys_sent++;
    if (batch_keys.size() < MAX_ITEMS) begin
      batch_keys.push_back(k);
    end else begin
      batch_dropped = 1'b1;
    end
    if (l) begin
      foreach (batch_keys[i]) begin
        pos = ordered.size();
        for (int j = 0; j < ordered.size(); j++) begin
          if (ordered[j] > batch_keys[i]) begin
            pos = j;
            break;
          end
        end
        ordered.insert(pos, batch_keys[i]);
      end
      foreach (ordered[i]) begin
        sorted_expect_q.push_back('{key: ordered[i],
                                    last: (i == ordered.size() - 1),
                                    ovf: batch_dropped});
      end
      batches_done++;
      if (batch_dropped) dropped_batches++;
      batch_keys.delete();
      batch_dropped = 1'b0;
    end
  endtask

  // Sends one item. The sender works in bursts; between bursts it mostly drops
  // in_valid for a random gap. Returns right after the accepting edge.
  task automatic send_key(input key_t k, input logic l);
    int gap;
    if (burst_left == 0) begin
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
      if (gap > 0) begin
        in_valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      burst_left = ($urandom_range(0, 5) == 0) ? 40 : $urandom_range(1, 8);
    end
    in_valid <= 1'b1;
    in_key   <= k;
    in_last  <= l;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    rank_accepted_key(k, l);
    burst_left--;
  endtask

  function automatic key_t pick_key(input val_mode_t m);
    key_t k;
    case (m)
      VAL_NARROW: k = int'($urandom_range(0, 8)) - 4;
      VAL_EDGE: begin
        case ($urandom_range(0, 5))
          0: k = KEY_MIN;
          1: k = KEY_MAX;
          2: k = '0;
          3: k = -1;
          4: k = KEY_MIN + 1;
          default: k = KEY_MAX - 1;
        endcase
      end
      default: k = key_t'($urandom);
    endcase
    return k;
  endfunction

  // Sends a batch of n keys with the marker on the n-th.
  task automatic send_batch(input int n, input val_mode_t m);
    for (int i = 0; i < n; i++) begin
      send_key(pick_key(m), (i == n - 1));
    end
  endtask

  // Receiver: stalls on a rotating pattern, redrawn when its age counter wraps,
  // or stays ready, and on request holds off for a counted stretch.
  always @(posedge clk) begin
    if (hold_left > 0) begin
      hold_left <= hold_left - 1;
      out_ready <= 1'b0;
    end else if (hold_req) begin
      hold_req  <= 1'b0;
      hold_left <= hold_len;
      out_ready <= 1'b0;
    end else begin
      out_ready <= (rx_mode == RX_ALWAYS) ? 1'b1 : stall_pattern[0];
    end
    if (pattern_age == 31) begin
      stall_pattern <= 8'($urandom) | 8'h01;
      pattern_age   <= 0;
    end else begin
      stall_pattern <= {stall_pattern[0], stall_pattern[7:1]};
      pattern_age   <= pattern_age + 1;
    end
  end

  // Result checker: each accepted item against the oldest expectation.
  always @(posedge clk) begin
    sorted_item_t want;
    if (rst_n && out_valid && out_ready) begin
      if (sorted_expect_q.size() == 0) begin
        report_mismatch("item with none expected", out_sorted_key, '0);
      end else begin
        want = sorted_expect_q.pop_front();
        items_checked++;
        if (out_sorted_key !== want.key)
          report_mismatch("sorted_key", out_sorted_key, want.key);
        if (out_last_out !== want.last)
          report_mismatch("last_out", 32'(out_last_out), 32'(want.last));
        if (out_overflow !== want.ovf)
          report_mismatch("overflow", 32'(out_overflow), 32'(want.ovf));
      end
    end
  end

  // Single keys, extremes, repeated keys and reversed order.
  task automatic test_directed();
    key_t mixed[8];
    mixed = '{32'sd0, -32'sd1, 32'sd1, KEY_MIN, KEY_MAX, KEY_MAX, KEY_MIN, 32'sd0};
    rx_mode <= RX_ALWAYS;
    send_key(KEY_MAX, 1'b1);
    send_key(KEY_MIN, 1'b1);
    send_key(KEY_MAX, 1'b0);
    send_key(KEY_MIN, 1'b1);
    foreach (mixed[i]) send_key(mixed[i], (i == 7));
    rx_mode <= RX_PATTERN;
    send_key(32'sd5, 1'b0);
    send_key(32'sd5, 1'b0);
    send_key(32'sd5, 1'b1);
    send_key(32'sd100, 1'b0);
    send_key(32'sd50, 1'b0);
    send_key(-32'sd50, 1'b0);
    send_key(-32'sd100, 1'b1);
  endtask

  // Exact capacity, then keys dropped before the marker, then the marker
  // itself dropped on a full store.
  task automatic test_capacity();
    rx_mode <= RX_PATTERN;
    send_batch(MAX_ITEMS, VAL_FULL);
    send_batch(MAX_ITEMS + 2, VAL_NARROW);
    send_batch(MAX_ITEMS + 1, VAL_EDGE);
  endtask

  // The receiver holds off while a batch sits in the chain; the next batch
  // is offered meanwhile and must wait at the input.
  task automatic test_backpressure();
    rx_mode  <= RX_PATTERN;
    hold_len <= HOLD_CYCLES;
    hold_req <= 1'b1;
    send_batch(48, VAL_FULL);
    send_batch(20, VAL_NARROW);
  endtask

  // Random batches, mostly short, with an occasional one near or past capacity.
  task automatic test_random();
    int        n;
    val_mode_t m;
    while (keys_sent < KEY_TARGET) begin
      n = ($urandom_range(0, 9) == 0) ? $urandom_range(50, 70) : $urandom_range(1, 12);
      case ($urandom_range(0, 3))
        0: m = VAL_NARROW;
        1: m = VAL_EDGE;
        default: m = VAL_FULL;
      endcase
      rx_mode <= ($urandom_range(0, 3) == 0) ? RX_ALWAYS : RX_PATTERN;
      send_batch(n, m);
    end
  endtask

  // Test sequence.
  initial begin
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    test_directed();
    test_capacity();
    test_backpressure();
    test_random();
    in_valid <= 1'b0;
    while (sorted_expect_q.size() != 0) @(posedge clk);
    repeat (2 * MAX_ITEMS + 8) @(posedge clk);
    $display("covered %0d keys in %0d batches, %0d of them with dropped keys",
             keys_sent, batches_done, dropped_batches);
    $display("checked %0d sorted items, %0d mismatches", items_checked, errors);
    if (errors == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule
